// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, skip while reset is held.
`define MIE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define MIE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== hdl/mie_pkg.sv =====
// Shared types and constants for the modular inverse unit.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package mie_pkg;

    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic update;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic rb_zero;
    } ctl_stat_t;

endpackage

`default_nettype wire

// ===== hdl/modular_inverse_ext_euclid_unit.sv =====
// Modular inverse unit, top level: modulus register, controller, datapath.
// Depends on mie_pkg, mie_controller and mie_datapath.
//
// Returns the inverse of each input word modulo the configured modulus by
// the extended Euclidean algorithm, one word at a time. In each Euclid
// step a bit-serial divider produces one quotient bit per cycle while the
// quotient-times-coefficient product is reduced mod the modulus in
// lockstep, then the pairs are updated and the new remainder is checked
// for zero. 32-bit values need at most about 46 Euclid steps. The result
// register frees the input side as soon as it is loaded. Write the
// modulus only while idle; it resets to 1000000007.
`default_nettype none

module modular_inverse_ext_euclid_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_wr_en,
    input  wire  [DATA_WIDTH-1:0]                cfg_wr_data,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [((DATA_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // operand
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [((DATA_WIDTH + 7) / 8) * 8-1:0] m_tdata,  // inverse
    output logic [0:0]                           m_tuser    // has_inverse
);

    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    logic [DATA_WIDTH-1:0] modulus_reg;
    logic [DATA_WIDTH-1:0] inverse;
    logic                  has_inverse;
    mie_pkg::ctl_cmd_t     cmd;
    mie_pkg::ctl_stat_t    stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= DATA_WIDTH'(mie_pkg::MODULUS_RESET);
        end else if (cfg_wr_en) begin
            modulus_reg <= cfg_wr_data;
        end
    end

    mie_controller #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    mie_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .cmd         (cmd),
        .stat        (stat),
        .operand     (s_tdata[DATA_WIDTH-1:0]),
        .modulus     (modulus_reg),
        .inverse     (inverse),
        .has_inverse (has_inverse)
    );

    assign m_tdata    = TDATA_W'(inverse);
    assign m_tuser[0] = has_inverse;

endmodule

`default_nettype wire

// ===== hdl/mie_datapath.sv =====
// Datapath: remainder pair, coefficient pair, bit-serial divider and
// modular multiply-accumulate, result registers. Depends on mie_pkg.
`default_nettype none

module mie_datapath #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                     aclk,
    input  wire  mie_pkg::ctl_cmd_t cmd,
    output mie_pkg::ctl_stat_t      stat,
    input  wire  [DATA_WIDTH-1:0]   operand,
    input  wire  [DATA_WIDTH-1:0]   modulus,
    output logic [DATA_WIDTH-1:0]   inverse,
    output logic                    has_inverse
);

    localparam int W = DATA_WIDTH;

    logic [W-1:0] m_reg;
    logic         mz_reg;
    logic [W-1:0] ra_reg;
    logic [W-1:0] rb_reg;
    logic [W-1:0] u_reg;
    logic [W-1:0] v_reg;
    logic [W-1:0] num_reg;
    logic [W-1:0] rem_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] inv_reg;
    logic         has_reg;

    logic [W:0]   rem_sh;
    logic         q_bit;
    logic [W-1:0] rem_next;
    logic [W+1:0] hs;
    logic [W+1:0] hm1;
    logic [W+1:0] hm2;
    logic [W-1:0] acc_next;
    logic [W:0]   diff;
    logic [W-1:0] nu;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_sh   = {rem_reg, num_reg[W-1]};
        q_bit    = (rem_sh >= {1'b0, rb_reg});
        rem_next = q_bit ? W'(rem_sh - {1'b0, rb_reg}) : rem_sh[W-1:0];
    end

    // Horner step of quotient * v mod m
    always_comb begin
        hs  = {1'b0, acc_reg, 1'b0} + {2'b00, (q_bit ? v_reg : {W{1'b0}})};
        hm1 = {2'b00, m_reg};
        hm2 = {1'b0, m_reg, 1'b0};
        if (hs >= hm2) begin
            acc_next = W'(hs - hm2);
        end else if (hs >= hm1) begin
            acc_next = W'(hs - hm1);
        end else begin
            acc_next = hs[W-1:0];
        end
    end

    // new coefficient u - t*v mod m
    always_comb begin
        diff = {1'b0, u_reg} - {1'b0, acc_reg};
        nu   = diff[W] ? W'(diff + {1'b0, m_reg}) : diff[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_reg  <= modulus;
            mz_reg <= (modulus == '0);
            ra_reg <= operand;
            rb_reg <= modulus;
            u_reg  <= (modulus > W'(1)) ? W'(1) : '0;
            v_reg  <= '0;
        end
        if (cmd.start) begin
            num_reg <= ra_reg;
            rem_reg <= '0;
            acc_reg <= '0;
        end
        if (cmd.step) begin
            num_reg <= {num_reg[W-2:0], 1'b0};
            rem_reg <= rem_next;
            acc_reg <= acc_next;
        end
        if (cmd.update) begin
            ra_reg <= rb_reg;
            rb_reg <= rem_reg;
            u_reg  <= v_reg;
            v_reg  <= nu;
        end
        if (cmd.emit) begin
            inv_reg <= mz_reg ? '0 : u_reg;
            has_reg <= !mz_reg && (ra_reg == W'(1));
        end
    end

    assign stat.rb_zero = (rb_reg == '0);
    assign inverse      = inv_reg;
    assign has_inverse  = has_reg;

endmodule

`default_nettype wire

// ===== hdl/mie_controller.sv =====
// Controller: sequences load, divide, update and output of each word.
// Depends on mie_pkg; drives the datapath through command signals.
`default_nettype none

module mie_controller #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire                     m_tready,
    output mie_pkg::ctl_cmd_t       cmd,
    input  wire  mie_pkg::ctl_stat_t stat
);

    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.rb_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.start  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DATA_WIDTH - 1)) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/mie_checker.sv =====
// Port-level checks for the modular inverse unit, bound to the top level.
// Depends on assert_macros.svh and modular_inverse_ext_euclid_unit.
`default_nettype none
`include "assert_macros.svh"

module mie_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire                                  aclk,
    input wire                                  aresetn,
    input wire                                  s_tvalid,
    input wire                                  s_tready,
    input wire                                  m_tvalid,
    input wire                                  m_tready,
    input wire [((DATA_WIDTH + 7) / 8) * 8-1:0] m_tdata,
    input wire [0:0]                            m_tuser
);

    `MIE_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")
    `MIE_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "input taken while a word is in progress")
    `MIE_ASSERT(a_no_instant_result, s_tvalid && s_tready && !m_tvalid |=> !m_tvalid, "result shown in the cycle after accept")
    `MIE_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

bind modular_inverse_ext_euclid_unit mie_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_mie_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
